// ===== hw/rtl/ett_pkg.sv =====
// Shared types, constants and helpers for the event timer table.
`timescale 1ns / 1ps

package ett_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FIRED = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] reload;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } seq_status_t;

  function automatic logic [3:0] to_slot(input idx_t idx);
    logic [IDX_W+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

endpackage

// ===== hw/rtl/event_timer_table_unit.sv =====
// Top level of the event timer table: sequencer, slot memory and checks.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    req_type, slot_id, initial_delay, period
//   out_     output     out_valid / out_ready  status, result_slot, last
//
// Allocate, free and unknown requests each give one last-marked result.
// A tick scans every slot: the slot memory has one read port and one write
// port, so the scan reads and updates one slot per cycle unless a full output
// register stalls it; the flush state then delivers the last-marked result.
// Reset clears all slots to inactive; the slot memory is not cleared.
`timescale 1ns / 1ps

module event_timer_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_slot_id,
  input  logic [15:0] in_initial_delay,
  input  logic [15:0] in_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_result_slot,
  output logic        out_last
);

  ett_pkg::mem_req_t    mem_req;
  ett_pkg::entry_t      mem_rdata;
  ett_pkg::seq_status_t seq_status;

  ett_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_slot_id       (in_slot_id),
    .in_initial_delay (in_initial_delay),
    .in_period        (in_period),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_slot  (out_result_slot),
    .out_last         (out_last),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .status           (seq_status)
  );

  ett_slot_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    seq_status.busy |-> !in_ready)
    else $error("input accepted during a tick scan");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == ett_pkg::REQ_TICK) |=> seq_status.busy)
    else $error("tick transfer did not start a scan");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type != ett_pkg::REQ_TICK) |=> (out_valid && out_last))
    else $error("single-result request gave no last result");

  a_scan_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(seq_status.busy) |-> (out_valid && out_last && !seq_status.pend_valid))
    else $error("tick ended without a last-marked result");
`endif

endmodule

// ===== hw/rtl/ett_slot_mem.sv =====
// Slot memory holding countdown and reload values, with a registered read.
`timescale 1ns / 1ps

module ett_slot_mem (
  input  logic             clk,
  input  ett_pkg::mem_req_t req,
  output ett_pkg::entry_t   rdata
);

  ett_pkg::entry_t mem_r [ett_pkg::SLOT_COUNT];
  ett_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ett_seq.sv =====
// Request sequencer: active bits, slot scan, result ordering and output register.
`timescale 1ns / 1ps

module ett_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [3:0]           in_slot_id,
  input  logic [15:0]          in_initial_delay,
  input  logic [15:0]          in_period,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [3:0]           out_result_slot,
  output logic                 out_last,
  output ett_pkg::mem_req_t    mem_req,
  input  ett_pkg::entry_t      mem_rdata,
  output ett_pkg::seq_status_t status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  ett_pkg::idx_t                  proc_r, proc_nxt;
  logic [ett_pkg::SLOT_COUNT-1:0] active_r, active_nxt;
  logic                           pend_v_r, pend_v_nxt;
  ett_pkg::idx_t                  pend_idx_r, pend_idx_nxt;
  logic [ett_pkg::REP_W-1:0]      rep_r, rep_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic [3:0]                     out_slot_r, out_slot_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           out_can;
  logic                           accept;
  logic                           found;
  ett_pkg::idx_t                  free_idx;
  logic [ett_pkg::IDX_W+3:0]      sid_wide;
  ett_pkg::idx_t                  sid_idx;
  logic                           cur_active;
  logic                           fire;
  logic                           record;
  logic                           need_emit;
  logic                           stall;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = ett_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        found    = 1'b1;
        free_idx = ett_pkg::idx_t'(i);
      end
    end
  end

  assign sid_wide   = {{ett_pkg::IDX_W{1'b0}}, in_slot_id};
  assign sid_idx    = sid_wide[ett_pkg::IDX_W-1:0];
  assign out_can    = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && out_can;
  assign accept     = in_valid && in_ready;
  assign cur_active = active_r[proc_r];
  assign fire       = cur_active && (mem_rdata.count <= 16'd1);
  assign record     = fire && (rep_r < ett_pkg::REP_W'(ett_pkg::MAX_RESULTS));
  assign need_emit  = record && pend_v_r;
  assign stall      = need_emit && !out_can;

  always_comb begin
    state_nxt      = state_r;
    proc_nxt       = proc_r;
    active_nxt     = active_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    rep_nxt        = rep_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            ett_pkg::REQ_ALLOC: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (found) begin
                active_nxt[free_idx] = 1'b1;
                mem_req.we           = 1'b1;
                mem_req.waddr        = free_idx;
                mem_req.wdata.count  = in_initial_delay;
                mem_req.wdata.reload = in_period;
                out_status_nxt       = ett_pkg::ST_DONE;
                out_slot_nxt         = ett_pkg::to_slot(free_idx);
              end else begin
                out_status_nxt = ett_pkg::ST_FULL;
                out_slot_nxt   = 4'd0;
              end
            end
            ett_pkg::REQ_FREE: begin
              if (32'(in_slot_id) < ett_pkg::SLOT_COUNT) begin
                active_nxt[sid_idx] = 1'b0;
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = ett_pkg::ST_DONE;
              out_slot_nxt   = in_slot_id;
              out_last_nxt   = 1'b1;
            end
            ett_pkg::REQ_TICK: begin
              state_nxt  = S_SCAN;
              proc_nxt   = '0;
              pend_v_nxt = 1'b0;
              rep_nxt    = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ett_pkg::ST_DONE;
              out_slot_nxt   = 4'd0;
              out_last_nxt   = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_req.raddr = stall ? proc_r : ett_pkg::idx_t'(proc_r + 1'b1);
        if (!stall) begin
          if (cur_active) begin
            if (fire) begin
              if (mem_rdata.reload != 16'd0) begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = proc_r;
                mem_req.wdata.count  = mem_rdata.reload;
                mem_req.wdata.reload = mem_rdata.reload;
              end else begin
                active_nxt[proc_r] = 1'b0;
              end
            end else begin
              mem_req.we           = 1'b1;
              mem_req.waddr        = proc_r;
              mem_req.wdata.count  = mem_rdata.count - 16'd1;
              mem_req.wdata.reload = mem_rdata.reload;
            end
          end
          if (need_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ett_pkg::ST_FIRED;
            out_slot_nxt   = ett_pkg::to_slot(pend_idx_r);
            out_last_nxt   = 1'b0;
          end
          if (record) begin
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = proc_r;
            rep_nxt      = rep_r + 1'b1;
          end
          if (proc_r == ett_pkg::idx_t'(ett_pkg::SLOT_COUNT - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            proc_nxt = ett_pkg::idx_t'(proc_r + 1'b1);
          end
        end
      end
      S_FLUSH: begin
        if (out_can) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_v_r) begin
            out_status_nxt = ett_pkg::ST_FIRED;
            out_slot_nxt   = ett_pkg::to_slot(pend_idx_r);
          end else begin
            out_status_nxt = ett_pkg::ST_DONE;
            out_slot_nxt   = 4'd0;
          end
          pend_v_nxt = 1'b0;
          rep_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      proc_r      <= '0;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_r      <= proc_nxt;
      active_r    <= active_nxt;
      pend_v_r    <= pend_v_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_slot   = out_slot_r;
  assign out_last          = out_last_r;
  assign status.busy       = (state_r != S_IDLE);
  assign status.pend_valid = pend_v_r;

endmodule
